// ===== design/x86ieu_pkg.sv =====
`default_nettype none

package x86ieu_pkg;

  typedef enum logic [2:0] {
    OP_MOV = 3'd0,
    OP_ADD = 3'd1,
    OP_ADC = 3'd2,
    OP_SUB = 3'd3,
    OP_SBB = 3'd4,
    OP_CMP = 3'd5
  } op_t;

  localparam logic [1:0] SRC_REG   = 2'd0;
  localparam logic [1:0] SRC_IMM   = 2'd1;
  localparam logic       DEST_REG  = 1'b0;
  localparam logic       DEST_MEM  = 1'b1;
  localparam logic [1:0] PART_HIGH = 2'd1;
  localparam int         PHYS_BITS = 20;

  typedef struct packed {
    logic overflow;
    logic sign;
    logic zero;
    logic carry;
  } flags_t;

  typedef struct packed {
    logic [2:0]  op;
    logic        wide;
    logic [1:0]  src_kind;
    logic [2:0]  src_reg;
    logic [1:0]  src_part;
    logic        dest_kind;
    logic [2:0]  dest_reg;
    logic [1:0]  dest_part;
    logic [15:0] imm;
    logic        base_en;
    logic [2:0]  base_reg;
    logic        index_en;
    logic [2:0]  index_reg;
    logic [15:0] disp;
    logic        uses_mem;
  } s1_t;

  typedef struct packed {
    logic [2:0]           op;
    logic                 wide;
    logic [1:0]           src_kind;
    logic [1:0]           src_part;
    logic                 dest_kind;
    logic [2:0]           dest_reg;
    logic [1:0]           dest_part;
    logic [15:0]          imm;
    logic                 uses_mem;
    logic [PHYS_BITS-1:0] phys;
    logic                 swap;
  } s2_t;

  function automatic logic [15:0] reg_part(input logic [15:0] w, input logic [1:0] part,
                                           input logic wide);
    logic [15:0] v;
    if (wide) begin
      v = w;
    end else if (part == PART_HIGH) begin
      v = {8'h00, w[15:8]};
    end else begin
      v = {8'h00, w[7:0]};
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== design/x86_16_integer_execute_unit_top.sv =====
`default_nettype none

// Executes one MOV/ADD/ADC/SUB/SBB/CMP per item, byte or word, against an internal
// register file, flag register and byte-wide data memory. No item is taken while the
// last is in the address stage or held in stage 2 by out_stall; a result moves from
// the stage 1 to the stage 2 registers, then to the output register. Two registered
// reads lie in series: the address registers from the register file, then the operands
// from the register file and the data memory, ahead of the read-modify-write. The data
// memory is split into even and odd byte banks so a word, aligned or not, is read and
// written in one access. Memory contents are undefined until written; registers and
// flags reset to zero. data_segment may be written only while the unit is idle.
module x86_16_integer_execute_unit_top
  import x86ieu_pkg::*;
#(
  parameter int MEM_ADDR_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [15:0]          cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [2:0]           opcode,
  input  wire logic                 wide,
  input  wire logic [1:0]           src_kind,
  input  wire logic [2:0]           src_reg,
  input  wire logic [1:0]           src_part,
  input  wire logic                 dest_kind,
  input  wire logic [2:0]           dest_reg,
  input  wire logic [1:0]           dest_part,
  input  wire logic [15:0]          immediate,
  input  wire logic [3:0]           ea_base,
  input  wire logic [3:0]           ea_index,
  input  wire logic [15:0]          displacement,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [15:0]               result_value,
  output logic                      carry_flag,
  output logic                      zero_flag,
  output logic                      sign_flag,
  output logic                      overflow_flag,
  output logic                      mem_write,
  output logic [PHYS_BITS-1:0]      mem_address
);

  localparam int BANK_BITS  = MEM_ADDR_BITS - 1;
  localparam int BANK_DEPTH = 2 ** BANK_BITS;

  logic [15:0] data_segment;

  logic [15:0] rf [0:7];
  logic [7:0]  rf_ok;
  logic [15:0] rf_a_q;
  logic [15:0] rf_b_q;
  logic [2:0]  rf_addr_a;
  logic [2:0]  rf_addr_b;
  logic        rf_rd_en;
  logic        rf_we;
  logic [15:0] rf_wdata;

  logic        wb_valid;
  logic [2:0]  wb_reg;
  logic [15:0] wb_word;

  logic [7:0] mem_even [0:BANK_DEPTH-1];
  logic [7:0] mem_odd  [0:BANK_DEPTH-1];
  logic [7:0] even_q;
  logic [7:0] odd_q;

  flags_t status_flags;

  logic accept;
  logic s1_valid;
  s1_t  s1;
  logic s2_valid;
  s2_t  s2;
  logic s2_go;
  logic [BANK_BITS-1:0] s2_even_addr;
  logic [BANK_BITS-1:0] s2_odd_addr;

  // stage 1: effective address
  logic [15:0]              base_val;
  logic [15:0]              index_val;
  logic [15:0]              offset;
  logic [PHYS_BITS-1:0]     phys;
  logic [MEM_ADDR_BITS-1:0] addr_a;
  logic [MEM_ADDR_BITS-1:0] addr_b;
  logic [BANK_BITS-1:0]     even_addr;
  logic [BANK_BITS-1:0]     odd_addr;

  // stage 2: operands, ALU, write-back
  logic [7:0]  lo_b;
  logic [7:0]  hi_b;
  logic [15:0] mem_word;
  logic [15:0] src_val;
  logic [15:0] dst_val;
  logic [15:0] mask;
  logic [15:0] top;
  logic        cin;
  logic [16:0] sum;
  logic [16:0] diff;
  logic [15:0] res;
  logic        writes;
  logic        flags_upd;
  flags_t      flags_new;
  flags_t      flags_after;
  logic        mem_we;
  logic        even_we;
  logic        odd_we;
  logic [7:0]  even_wdata;
  logic [7:0]  odd_wdata;

  assign s2_go    = s2_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid || (s2_valid && !s2_go);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_segment <= '0;
    end else if (cfg_we) begin
      data_segment <= cfg_wdata;
    end
  end

  // register file: ports carry address registers at accept, source/destination in stage 1
  assign rf_addr_a = s1_valid ? s1.src_reg  : ea_base[2:0];
  assign rf_addr_b = s1_valid ? s1.dest_reg : ea_index[2:0];
  assign rf_rd_en  = accept || s1_valid;

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[s2.dest_reg] <= rf_wdata;
    end
    if (rf_rd_en) begin
      rf_a_q <= rf_ok[rf_addr_a] ? rf[rf_addr_a] : 16'h0000;
      rf_b_q <= rf_ok[rf_addr_b] ? rf[rf_addr_b] : 16'h0000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_ok    <= '0;
      wb_valid <= 1'b0;
    end else if (rf_we) begin
      rf_ok[s2.dest_reg] <= 1'b1;
      wb_valid           <= 1'b1;
    end
  end

  // last register write, forwarded to the address read taken on the same edge
  always_ff @(posedge clk) begin
    if (rf_we) begin
      wb_reg  <= s2.dest_reg;
      wb_word <= rf_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.op        <= opcode;
      s1.wide      <= wide;
      s1.src_kind  <= src_kind;
      s1.src_reg   <= src_reg;
      s1.src_part  <= src_part;
      s1.dest_kind <= dest_kind;
      s1.dest_reg  <= dest_reg;
      s1.dest_part <= dest_part;
      s1.imm       <= immediate;
      s1.base_en   <= !ea_base[3];
      s1.base_reg  <= ea_base[2:0];
      s1.index_en  <= !ea_index[3];
      s1.index_reg <= ea_index[2:0];
      s1.disp      <= displacement;
      s1.uses_mem  <= (src_kind != SRC_REG && src_kind != SRC_IMM) || (dest_kind == DEST_MEM);
    end
  end

  always_comb begin
    base_val  = (wb_valid && wb_reg == s1.base_reg)  ? wb_word : rf_a_q;
    index_val = (wb_valid && wb_reg == s1.index_reg) ? wb_word : rf_b_q;
    offset    = s1.disp + (s1.base_en ? base_val : 16'h0000)
                        + (s1.index_en ? index_val : 16'h0000);
    phys      = {data_segment, 4'h0} + {4'h0, offset};
    addr_a    = phys[MEM_ADDR_BITS-1:0];
    addr_b    = addr_a + {{(MEM_ADDR_BITS-1){1'b0}}, 1'b1};
    odd_addr  = addr_a[MEM_ADDR_BITS-1:1];
    even_addr = addr_a[0] ? addr_b[MEM_ADDR_BITS-1:1] : addr_a[MEM_ADDR_BITS-1:1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_valid) begin
      s2_valid <= 1'b1;
    end else if (s2_go) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2.op           <= s1.op;
      s2.wide         <= s1.wide;
      s2.src_kind     <= s1.src_kind;
      s2.src_part     <= s1.src_part;
      s2.dest_kind    <= s1.dest_kind;
      s2.dest_reg     <= s1.dest_reg;
      s2.dest_part    <= s1.dest_part;
      s2.imm          <= s1.imm;
      s2.uses_mem     <= s1.uses_mem;
      s2.phys         <= phys;
      s2.swap         <= addr_a[0];
      s2_even_addr    <= even_addr;
      s2_odd_addr     <= odd_addr;
    end
  end

  // byte banks: read in stage 1, written back at the end of stage 2
  always_ff @(posedge clk) begin
    if (even_we) begin
      mem_even[s2_even_addr] <= even_wdata;
    end
    if (s1_valid) begin
      even_q <= mem_even[even_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (odd_we) begin
      mem_odd[s2_odd_addr] <= odd_wdata;
    end
    if (s1_valid) begin
      odd_q <= mem_odd[odd_addr];
    end
  end

  always_comb begin
    lo_b     = s2.swap ? odd_q : even_q;
    hi_b     = s2.swap ? even_q : odd_q;
    mem_word = s2.wide ? {hi_b, lo_b} : {8'h00, lo_b};

    case (s2.src_kind)
      SRC_REG: src_val = reg_part(rf_a_q, s2.src_part, s2.wide);
      SRC_IMM: src_val = s2.wide ? s2.imm : {8'h00, s2.imm[7:0]};
      default: src_val = mem_word;
    endcase
    dst_val = (s2.dest_kind == DEST_REG) ? reg_part(rf_b_q, s2.dest_part, s2.wide) : mem_word;

    mask = s2.wide ? 16'hFFFF : 16'h00FF;
    top  = s2.wide ? 16'h8000 : 16'h0080;
    cin  = status_flags.carry && (op_t'(s2.op) == OP_ADC || op_t'(s2.op) == OP_SBB);
    sum  = {1'b0, dst_val} + {1'b0, src_val} + {16'h0000, cin};
    diff = {1'b0, dst_val} - {1'b0, src_val} - {16'h0000, cin};

    res                = src_val;
    writes             = 1'b0;
    flags_upd          = 1'b0;
    flags_new.carry    = 1'b0;
    flags_new.overflow = 1'b0;
    unique case (op_t'(s2.op)) inside
      OP_MOV: begin
        writes = 1'b1;
      end
      OP_ADD, OP_ADC: begin
        res                = sum[15:0] & mask;
        writes             = 1'b1;
        flags_upd          = 1'b1;
        flags_new.carry    = s2.wide ? sum[16] : sum[8];
        flags_new.overflow = |(~(dst_val ^ src_val) & (dst_val ^ res) & top);
      end
      OP_SUB, OP_SBB, OP_CMP: begin
        res                = diff[15:0] & mask;
        writes             = (op_t'(s2.op) != OP_CMP);
        flags_upd          = 1'b1;
        flags_new.carry    = diff[16];
        flags_new.overflow = |((dst_val ^ src_val) & (dst_val ^ res) & top);
      end
      default: begin
        res = src_val;
      end
    endcase
    flags_new.zero = (res == 16'h0000);
    flags_new.sign = |(res & top);
    flags_after    = flags_upd ? flags_new : status_flags;

    rf_we    = s2_go && writes && (s2.dest_kind == DEST_REG);
    rf_wdata = s2.wide ? res :
               (s2.dest_part == PART_HIGH) ? {res[7:0], rf_b_q[7:0]} : {rf_b_q[15:8], res[7:0]};

    mem_we     = writes && (s2.dest_kind == DEST_MEM);
    even_we    = s2_go && mem_we && (!s2.swap || s2.wide);
    odd_we     = s2_go && mem_we && (s2.swap || s2.wide);
    even_wdata = s2.swap ? res[15:8] : res[7:0];
    odd_wdata  = s2.swap ? res[7:0] : res[15:8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_flags <= '0;
    end else if (s2_go && flags_upd) begin
      status_flags <= flags_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      result_value  <= res;
      carry_flag    <= flags_after.carry;
      zero_flag     <= flags_after.zero;
      sign_flag     <= flags_after.sign;
      overflow_flag <= flags_after.overflow;
      mem_write     <= mem_we;
      mem_address   <= s2.uses_mem ? s2.phys : '0;
    end
  end

`ifndef SYNTHESIS
  a_stage_exclusive: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !s2_valid)
    else $error("address stage and execute stage both occupied");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !(in_valid && !in_stall))
    else $error("item taken while address stage busy");

  a_forward_match: assert property (@(posedge clk) disable iff (rst)
    wb_valid |-> (rf_ok[wb_reg] && rf[wb_reg] == wb_word))
    else $error("forwarded register word differs from register file");
`endif

endmodule

`default_nettype wire

// ===== dv/x86_16_integer_execute_unit_top_test.sv =====
module x86_16_integer_execute_unit_top_test
  import x86ieu_pkg::*;
;

  localparam int MEM_BITS = 16;
  localparam int POOL_SPAN = 31;
  localparam int HOLD_CYCLES = 150;

  localparam logic [1:0] SRC_MEM = 2'd2;
  localparam logic [1:0] SRC_SPARE = 2'd3;
  localparam logic [1:0] PART_LOW = 2'd0;
  localparam logic [1:0] PART_WORD = 2'd2;
  localparam logic [1:0] PART_SPARE = 2'd3;
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [3:0] EA_NONE = 4'd8;
  localparam logic [3:0] EA_BAD_LO = 4'd9;
  localparam logic [3:0] EA_BAD_HI = 4'd15;

  typedef struct packed {
    logic [2:0]  op;
    logic        wide;
    logic [1:0]  src_kind;
    logic [2:0]  src_reg;
    logic [1:0]  src_part;
    logic        dest_kind;
    logic [2:0]  dest_reg;
    logic [1:0]  dest_part;
    logic [15:0] imm;
    logic [3:0]  base;
    logic [3:0]  idx;
    logic [15:0] disp;
  } insn_t;

  typedef struct packed {
    logic [15:0]          value;
    logic                 carry;
    logic                 zero;
    logic                 sign;
    logic                 ovf;
    logic                 stored;
    logic [PHYS_BITS-1:0] addr;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] opcode = '0;
  logic wide = 1'b0;
  logic [1:0] src_kind = '0;
  logic [2:0] src_reg = '0;
  logic [1:0] src_part = '0;
  logic dest_kind = 1'b0;
  logic [2:0] dest_reg = '0;
  logic [1:0] dest_part = '0;
  logic [15:0] immediate = '0;
  logic [3:0] ea_base = '0;
  logic [3:0] ea_index = '0;
  logic [15:0] displacement = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] result_value;
  logic carry_flag, zero_flag, sign_flag, overflow_flag, mem_write;
  logic [PHYS_BITS-1:0] mem_address;

  logic quiet = 1'b0;
  logic hold_off = 1'b0;

  // execution state as the unit should hold it
  logic [15:0] gpr [8];
  flags_t flg;
  logic [15:0] seg;
  logic [7:0] dmem [1 << MEM_BITS];
  bit written [1 << MEM_BITS];

  outcome_t pending_outcomes [$];
  int errors = 0;
  int n_issued = 0;
  int n_checked = 0;
  int n_stores = 0;
  int n_segs = 0;

  x86_16_integer_execute_unit_top #(.MEM_ADDR_BITS(MEM_BITS)) dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .wide(wide), .src_kind(src_kind), .src_reg(src_reg),
    .src_part(src_part), .dest_kind(dest_kind), .dest_reg(dest_reg),
    .dest_part(dest_part), .immediate(immediate), .ea_base(ea_base),
    .ea_index(ea_index), .displacement(displacement),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_value(result_value), .carry_flag(carry_flag), .zero_flag(zero_flag),
    .sign_flag(sign_flag), .overflow_flag(overflow_flag), .mem_write(mem_write),
    .mem_address(mem_address)
  );

  always #5 clk = ~clk;

  initial begin
    for (int i = 0; i < 8; i++) gpr[i] = '0;
    flg = '0;
    seg = '0;
  end

  function automatic logic [PHYS_BITS-1:0] operand_phys(insn_t it);
    logic [15:0] off;
    off = it.disp;
    if (it.base < EA_NONE) off = off + gpr[it.base[2:0]];
    if (it.idx < EA_NONE) off = off + gpr[it.idx[2:0]];
    return {seg, 4'h0} + PHYS_BITS'(off);
  endfunction

  function automatic logic [15:0] reg_field(logic [2:0] n, logic [1:0] part, logic w);
    if (w) return gpr[n];
    if (part == PART_HIGH) return {8'h00, gpr[n][15:8]};
    return {8'h00, gpr[n][7:0]};
  endfunction

  function automatic void reg_put(logic [2:0] n, logic [1:0] part, logic w,
                                  logic [15:0] v);
    if (w) gpr[n] = v;
    else if (part == PART_HIGH) gpr[n][15:8] = v[7:0];
    else gpr[n][7:0] = v[7:0];
  endfunction

  // a word's upper byte wraps within the byte store
  function automatic logic [15:0] mem_get(logic [PHYS_BITS-1:0] pa, logic w);
    logic [MEM_BITS-1:0] lo, hi;
    lo = pa[MEM_BITS-1:0];
    hi = lo + MEM_BITS'(1);
    return w ? {dmem[hi], dmem[lo]} : {8'h00, dmem[lo]};
  endfunction

  function automatic void mem_put(logic [PHYS_BITS-1:0] pa, logic [15:0] v, logic w);
    logic [MEM_BITS-1:0] lo, hi;
    lo = pa[MEM_BITS-1:0];
    hi = lo + MEM_BITS'(1);
    dmem[lo] = v[7:0];
    written[lo] = 1'b1;
    if (w) begin
      dmem[hi] = v[15:8];
      written[hi] = 1'b1;
    end
  endfunction

  // true unless the item would use a memory byte never stored
  function automatic bit reads_ready(insn_t it);
    logic [PHYS_BITS-1:0] pa;
    logic [MEM_BITS-1:0] lo, hi;
    bit ok;
    pa = operand_phys(it);
    lo = pa[MEM_BITS-1:0];
    hi = lo + MEM_BITS'(1);
    ok = written[lo] && (!it.wide || written[hi]);
    if (it.src_kind >= SRC_MEM) return ok;
    if (it.dest_kind == DEST_MEM && it.op >= OP_ADD && it.op <= OP_CMP) return ok;
    return 1'b1;
  endfunction

  task automatic execute_insn(insn_t it);
    outcome_t res;
    logic [15:0] s, d, r, mask, top;
    logic [16:0] full;
    logic cin, mem_op, commit;
    logic [PHYS_BITS-1:0] pa;
    mask = it.wide ? 16'hFFFF : 16'h00FF;
    top = it.wide ? 16'h8000 : 16'h0080;
    mem_op = (it.src_kind >= SRC_MEM) || (it.dest_kind == DEST_MEM);
    pa = mem_op ? operand_phys(it) : '0;
    case (it.src_kind)
      SRC_REG: s = reg_field(it.src_reg, it.src_part, it.wide);
      SRC_IMM: s = it.imm & mask;
      default: s = mem_get(pa, it.wide);
    endcase
    if (it.dest_kind == DEST_MEM) d = mem_get(pa, it.wide);
    else d = reg_field(it.dest_reg, it.dest_part, it.wide);
    cin = (it.op == OP_ADC || it.op == OP_SBB) && flg.carry;
    r = s;
    commit = (it.op == OP_MOV);
    if (it.op >= OP_ADD && it.op <= OP_CMP) begin
      if (it.op <= OP_ADC) begin
        full = {1'b0, d} + {1'b0, s} + 17'(cin);
        r = full[15:0] & mask;
        flg.carry = full > {1'b0, mask};
        flg.overflow = |(~(d ^ s) & (d ^ r) & top);
      end else begin
        full = {1'b0, d} - {1'b0, s} - 17'(cin);
        r = full[15:0] & mask;
        flg.carry = {1'b0, d} < ({1'b0, s} + 17'(cin));
        flg.overflow = |((d ^ s) & (d ^ r) & top);
      end
      flg.zero = (r == 16'h0000);
      flg.sign = |(r & top);
      commit = (it.op != OP_CMP);
    end
    res.stored = 1'b0;
    if (commit) begin
      if (it.dest_kind == DEST_MEM) begin
        mem_put(pa, r, it.wide);
        res.stored = 1'b1;
        n_stores++;
      end else begin
        reg_put(it.dest_reg, it.dest_part, it.wide, r);
      end
    end
    res.value = r;
    res.carry = flg.carry;
    res.zero = flg.zero;
    res.sign = flg.sign;
    res.ovf = flg.overflow;
    res.addr = pa;
    pending_outcomes.push_back(res);
  endtask

  function automatic insn_t make_insn(logic [2:0] op, logic w, logic [1:0] sk,
                                      logic [2:0] sr, logic [1:0] sp, logic dk,
                                      logic [2:0] dr, logic [1:0] dp, logic [15:0] imm,
                                      logic [3:0] base, logic [3:0] idx,
                                      logic [15:0] disp);
    insn_t it;
    it.op = op;
    it.wide = w;
    it.src_kind = sk;
    it.src_reg = sr;
    it.src_part = sp;
    it.dest_kind = dk;
    it.dest_reg = dr;
    it.dest_part = dp;
    it.imm = imm;
    it.base = base;
    it.idx = idx;
    it.disp = disp;
    return it;
  endfunction

  function automatic logic [3:0] addr_reg_choice();
    int p;
    p = $urandom_range(99);
    if (p < 25) return EA_NONE;
    if (p < 35) return 4'($urandom_range(EA_BAD_HI, EA_BAD_LO));
    return 4'($urandom_range(7));
  endfunction

  // operands mostly land in a small window at both ends of the segment, so that
  // memory reads find stored bytes; items that would not are turned into stores
  function automatic insn_t random_insn();
    insn_t it;
    logic [15:0] target, bval, ival;
    int p;
    p = $urandom_range(99);
    if (p < 4) it.op = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
    else it.op = 3'($urandom_range(OP_CMP, OP_MOV));
    it.wide = 1'($urandom_range(1));
    p = $urandom_range(99);
    if (p < 35) it.src_kind = SRC_REG;
    else if (p < 65) it.src_kind = SRC_IMM;
    else if (p < 95) it.src_kind = SRC_MEM;
    else it.src_kind = SRC_SPARE;
    it.src_reg = 3'($urandom_range(7));
    it.src_part = 2'($urandom_range(3));
    it.dest_kind = ($urandom_range(99) < 30) ? DEST_MEM : DEST_REG;
    it.dest_reg = ($urandom_range(9) == 0) ? it.src_reg : 3'($urandom_range(7));
    it.dest_part = 2'($urandom_range(3));
    if ($urandom_range(99) < 15) begin
      case ($urandom_range(7))
        0: it.imm = 16'h0000;
        1: it.imm = 16'h0001;
        2: it.imm = 16'h007F;
        3: it.imm = 16'h0080;
        4: it.imm = 16'h00FF;
        5: it.imm = 16'h7FFF;
        6: it.imm = 16'h8000;
        default: it.imm = 16'hFFFF;
      endcase
    end else begin
      it.imm = 16'($urandom_range(16'hFFFF));
    end
    it.base = addr_reg_choice();
    it.idx = addr_reg_choice();
    if ($urandom_range(99) < 70) begin
      if ($urandom_range(1) == 1) target = 16'($urandom_range(POOL_SPAN));
      else target = 16'hFFFF - 16'($urandom_range(POOL_SPAN));
    end else begin
      target = 16'($urandom_range(16'hFFFF));
    end
    bval = (it.base < EA_NONE) ? gpr[it.base[2:0]] : 16'h0000;
    ival = (it.idx < EA_NONE) ? gpr[it.idx[2:0]] : 16'h0000;
    it.disp = target - bval - ival;
    if (!reads_ready(it)) begin
      it.op = OP_MOV;
      it.dest_kind = DEST_MEM;
      it.src_kind = ($urandom_range(1) == 1) ? SRC_REG : SRC_IMM;
    end
    return it;
  endfunction

  task automatic send_insn(insn_t it);
    if (!quiet && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= it.op;
    wide <= it.wide;
    src_kind <= it.src_kind;
    src_reg <= it.src_reg;
    src_part <= it.src_part;
    dest_kind <= it.dest_kind;
    dest_reg <= it.dest_reg;
    dest_part <= it.dest_part;
    immediate <= it.imm;
    ea_base <= it.base;
    ea_index <= it.idx;
    displacement <= it.disp;
    do @(posedge clk); while (in_stall);
    execute_insn(it);
    n_issued++;
  endtask

  task automatic run_random(int n);
    repeat (n) send_insn(random_insn());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic set_segment(logic [15:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    seg = v;
    n_segs++;
  endtask

  task automatic report_mismatch(string what, logic [19:0] got, logic [19:0] want);
    $display("%0t: %s mismatch, got %h expected %h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (hold_off) begin
      out_stall <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 20);
    end
  end

  always @(posedge clk) begin : check_outcome
    outcome_t want;
    if (!rst && out_valid && !out_stall) begin
      n_checked++;
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unexpected result", 20'(result_value), '0);
      end else begin
        want = pending_outcomes.pop_front();
        if (result_value !== want.value)
          report_mismatch("result_value", 20'(result_value), 20'(want.value));
        if (carry_flag !== want.carry)
          report_mismatch("carry_flag", 20'(carry_flag), 20'(want.carry));
        if (zero_flag !== want.zero)
          report_mismatch("zero_flag", 20'(zero_flag), 20'(want.zero));
        if (sign_flag !== want.sign)
          report_mismatch("sign_flag", 20'(sign_flag), 20'(want.sign));
        if (overflow_flag !== want.ovf)
          report_mismatch("overflow_flag", 20'(overflow_flag), 20'(want.ovf));
        if (mem_write !== want.stored)
          report_mismatch("mem_write", 20'(mem_write), 20'(want.stored));
        if (mem_address !== want.addr)
          report_mismatch("mem_address", 20'(mem_address), 20'(want.addr));
      end
    end
  end

  task automatic test_directed();
    send_insn(make_insn(OP_MOV, 1, SRC_IMM, 0, 0, DEST_REG, 0, PART_WORD, 16'h7FFF,
                        EA_NONE, EA_NONE, 16'h0000));
    send_insn(make_insn(OP_ADD, 1, SRC_IMM, 0, 0, DEST_REG, 0, PART_WORD, 16'h0001,
                        EA_NONE, EA_NONE, 16'h0000));
    send_insn(make_insn(OP_MOV, 0, SRC_IMM, 0, 0, DEST_REG, 1, PART_HIGH, 16'hAB80,
                        EA_NONE, EA_NONE, 16'h0000));
    send_insn(make_insn(OP_ADD, 0, SRC_REG, 1, PART_HIGH, DEST_REG, 1, PART_HIGH,
                        16'h0000, EA_NONE, EA_NONE, 16'h0000));
    send_insn(make_insn(OP_ADC, 0, SRC_IMM, 0, 0, DEST_REG, 2, PART_SPARE, 16'h00FF,
                        EA_NONE, EA_NONE, 16'h0000));
    send_insn(make_insn(OP_SUB, 1, SRC_IMM, 0, 0, DEST_REG, 3, PART_WORD, 16'h0001,
                        EA_NONE, EA_NONE, 16'h0000));
    send_insn(make_insn(OP_SBB, 1, SRC_REG, 0, PART_WORD, DEST_REG, 3, PART_WORD,
                        16'h0000, EA_NONE, EA_NONE, 16'h0000));
    send_insn(make_insn(OP_CMP, 1, SRC_IMM, 0, 0, DEST_REG, 0, PART_WORD, 16'h8000,
                        EA_NONE, EA_NONE, 16'h0000));
    // word store straddling the end of the segment
    send_insn(make_insn(OP_MOV, 1, SRC_IMM, 0, 0, DEST_MEM, 0, 0, 16'h1234,
                        EA_NONE, EA_NONE, 16'hFFFF));
    send_insn(make_insn(OP_MOV, 0, SRC_REG, 0, PART_HIGH, DEST_MEM, 0, 0, 16'h0000,
                        4'd3, EA_BAD_HI, 16'h0002));
    // both operands in memory
    send_insn(make_insn(OP_ADD, 1, SRC_MEM, 0, 0, DEST_MEM, 0, 0, 16'h0000,
                        EA_NONE, EA_NONE, 16'hFFFF));
    send_insn(make_insn(OP_SUB, 0, SRC_SPARE, 0, 0, DEST_REG, 4, PART_LOW, 16'h0000,
                        EA_NONE, EA_NONE, 16'hFFFF));
    send_insn(make_insn(OP_CMP, 0, SRC_IMM, 0, 0, DEST_MEM, 0, 0, 16'hFF80,
                        4'd3, EA_BAD_LO, 16'h0002));
    send_insn(make_insn(OP_SPARE_LO, 1, SRC_IMM, 0, 0, DEST_REG, 5, PART_WORD, 16'hFFFF,
                        EA_NONE, EA_NONE, 16'h0000));
    send_insn(make_insn(OP_SPARE_HI, 0, SRC_MEM, 0, 0, DEST_MEM, 0, 0, 16'h0000,
                        EA_NONE, EA_NONE, 16'hFFFF));
    send_insn(make_insn(OP_MOV, 1, SRC_IMM, 0, 0, DEST_REG, 2, PART_LOW, 16'h0000,
                        EA_NONE, EA_NONE, 16'h0000));
    send_insn(make_insn(OP_ADD, 0, SRC_MEM, 0, 0, DEST_REG, 5, PART_HIGH, 16'h0000,
                        EA_NONE, EA_NONE, 16'h0000));
    send_insn(make_insn(OP_SBB, 1, SRC_REG, 6, PART_WORD, DEST_MEM, 0, 0, 16'h0000,
                        4'd3, 4'd0, 16'h0001));
    send_insn(make_insn(OP_MOV, 0, SRC_REG, 3, PART_SPARE, DEST_REG, 7, PART_LOW,
                        16'h0000, EA_NONE, EA_NONE, 16'h0000));
    send_insn(make_insn(OP_ADC, 1, SRC_IMM, 0, 0, DEST_REG, 6, PART_WORD, 16'hFFFF,
                        EA_NONE, EA_NONE, 16'h0000));
  endtask

  task automatic test_segment_extremes();
    set_segment(16'hFFFF);
    run_random(150);
    set_segment(16'h0000);
    run_random(150);
    set_segment(16'h8000);
    run_random(150);
  endtask

  task automatic test_random_traffic();
    repeat (4) begin
      set_segment(16'($urandom_range(16'hFFFF)));
      run_random(250);
    end
  endtask

  task automatic test_full_rate();
    set_segment(16'($urandom_range(16'hFFFF)));
    quiet <= 1'b1;
    run_random(200);
    quiet <= 1'b0;
  endtask

  // receiver holds off while items keep coming, so the unit backs up
  task automatic test_backpressure();
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    run_random(60);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_segment_extremes();
    test_random_traffic();
    test_full_rate();
    test_backpressure();
    drain();
    repeat (8) @(posedge clk);
    $display("ran %0d instructions (%0d memory stores) over %0d segment settings",
             n_issued, n_stores, n_segs);
    $display("checked %0d results, %0d field mismatches", n_checked, errors);
    if (errors == 0) begin
      $display("[x86_16_integer_execute_unit_top] OK");
    end else begin
      $display("[x86_16_integer_execute_unit_top] ERROR");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("run timed out with %0d results outstanding", pending_outcomes.size());
    $display("[x86_16_integer_execute_unit_top] ERROR");
    $finish;
  end

endmodule
